[design/tsm_pkg.sv]
// tsm_pkg: shared types and constants of the timestamp stream merger
// depends on nothing; imported by every other file of the block

package tsm_pkg;

  // default sizing, used as parameter defaults by the top level
  localparam int TSM_MAX_STREAMS = 8;
  localparam int TSM_QUEUE_DEPTH = 2;

  // field widths
  localparam int ID_W    = 3;
  localparam int SEC_W   = 32;
  localparam int NS_W    = 30;
  localparam int TAG_W   = 32;
  localparam int COUNT_W = 4;
  localparam int OFFNS_W = 31;
  localparam int SUM_W   = 33;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // nanosecond normalization thresholds and corrections
  localparam logic signed [SUM_W-1:0] NEG_ONE_SEC = -33'sd1000000000;
  localparam logic signed [SUM_W-1:0] ONE_SEC     = 33'sd1000000000;
  localparam logic signed [SUM_W-1:0] TWO_SEC     = 33'sd2000000000;
  localparam logic signed [SUM_W-1:0] NEG_TWO_SEC = -33'sd2000000000;
  localparam logic signed [SUM_W-1:0] ZERO_SEC    = 33'sd0;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STREAM_COUNT = 2'd0,
    CFG_OFFSET_SEC   = 2'd1,
    CFG_OFFSET_NS    = 2'd2
  } tsm_cfg_idx_t;

  // configuration register set
  typedef struct packed {
    logic [COUNT_W-1:0] stream_count;
    logic [SEC_W-1:0]   offset_seconds;
    logic [OFFNS_W-1:0] offset_nanoseconds;
  } tsm_cfg_t;

  // classified item passed from front to back through the queue
  typedef struct packed {
    logic [ID_W-1:0]  stream_id;
    logic             eos;
    logic [SEC_W-1:0] sec;
    logic [NS_W-1:0]  ns;
    logic [TAG_W-1:0] tag;
  } tsm_item_t;

endpackage

[design/tsm_in_if.sv]
// tsm_in_if: input record channel, valid/ready with the record fields
// depends on tsm_pkg for field widths

interface tsm_in_if import tsm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  stream_id;
  logic             end_of_stream;
  logic [SEC_W-1:0] time_seconds;
  logic [NS_W-1:0]  time_nanoseconds;
  logic             is_l1accept;
  logic [TAG_W-1:0] record_tag;

  modport source (
    output valid, stream_id, end_of_stream, time_seconds, time_nanoseconds,
           is_l1accept, record_tag,
    input  ready
  );

  modport sink (
    input  valid, stream_id, end_of_stream, time_seconds, time_nanoseconds,
           is_l1accept, record_tag,
    output ready
  );
endinterface

[design/tsm_out_if.sv]
// tsm_out_if: merged result channel, valid/ready with the result fields
// depends on tsm_pkg for field widths

interface tsm_out_if import tsm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  out_stream;
  logic [SEC_W-1:0] out_seconds;
  logic [NS_W-1:0]  out_nanoseconds;
  logic [TAG_W-1:0] out_tag;
  logic             all_done;

  modport source (
    output valid, out_stream, out_seconds, out_nanoseconds, out_tag, all_done,
    input  ready
  );

  modport sink (
    input  valid, out_stream, out_seconds, out_nanoseconds, out_tag, all_done,
    output ready
  );
endinterface

[design/tsm_front.sv]
// tsm_front: accepts input transactions and applies the time offset
// depends on tsm_pkg and tsm_in_if; feeds tsm_queue

module tsm_front import tsm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  tsm_cfg_t  cfg,
  tsm_in_if.sink    in_chan,
  output logic      push_valid,
  input  logic      push_ready,
  output tsm_item_t push_item
);

  logic                    s1_valid_r;
  logic [ID_W-1:0]         s1_id_r;
  logic                    s1_eos_r;
  logic                    s1_l1_r;
  logic [SEC_W-1:0]        s1_sec_r;
  logic [NS_W-1:0]         s1_ns_r;
  logic [TAG_W-1:0]        s1_tag_r;
  logic signed [SUM_W-1:0] s1_sum_ns_r;
  logic [SEC_W-1:0]        s1_sum_sec_r;

  logic                    accept;
  logic                    lt_neg1;
  logic                    lt_zero;
  logic                    lt_one;
  logic                    lt_two;
  logic signed [2:0]       carry;
  logic signed [SUM_W-1:0] corr;
  logic signed [SUM_W-1:0] adj_sum;
  logic [SEC_W-1:0]        adj_sec;

  // stage holds one transaction; it moves on when the queue takes it
  assign in_chan.ready = !s1_valid_r || push_ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign push_valid    = s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (push_ready) begin
      s1_valid_r <= 1'b0;
    end
  end

  // raw fields plus the offset sums
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_id_r      <= in_chan.stream_id;
      s1_eos_r     <= in_chan.end_of_stream;
      s1_l1_r      <= in_chan.is_l1accept;
      s1_sec_r     <= in_chan.time_seconds;
      s1_ns_r      <= in_chan.time_nanoseconds;
      s1_tag_r     <= in_chan.record_tag;
      s1_sum_ns_r  <= $signed({3'b000, in_chan.time_nanoseconds})
                    + $signed({{2{cfg.offset_nanoseconds[OFFNS_W-1]}},
                               cfg.offset_nanoseconds});
      s1_sum_sec_r <= in_chan.time_seconds + cfg.offset_seconds;
    end
  end

  // fold nanosecond sum into 0..999999999, carry or borrow into seconds
  always_comb begin
    lt_neg1 = s1_sum_ns_r < NEG_ONE_SEC;
    lt_zero = s1_sum_ns_r < ZERO_SEC;
    lt_one  = s1_sum_ns_r < ONE_SEC;
    lt_two  = s1_sum_ns_r < TWO_SEC;
    if (lt_neg1) begin
      carry = -3'sd2;
      corr  = TWO_SEC;
    end else if (lt_zero) begin
      carry = -3'sd1;
      corr  = ONE_SEC;
    end else if (lt_one) begin
      carry = 3'sd0;
      corr  = ZERO_SEC;
    end else if (lt_two) begin
      carry = 3'sd1;
      corr  = NEG_ONE_SEC;
    end else begin
      carry = 3'sd2;
      corr  = NEG_TWO_SEC;
    end
    adj_sum = s1_sum_ns_r + corr;
    adj_sec = s1_sum_sec_r + {{(SEC_W-3){carry[2]}}, carry};
  end

  // l1accept records keep their time unchanged
  always_comb begin
    push_item.stream_id = s1_id_r;
    push_item.eos       = s1_eos_r;
    push_item.sec       = s1_l1_r ? s1_sec_r : adj_sec;
    push_item.ns        = s1_l1_r ? s1_ns_r : adj_sum[NS_W-1:0];
    push_item.tag       = s1_tag_r;
  end

endmodule

[design/tsm_queue.sv]
// tsm_queue: short fifo of classified items between front and back
// depends on tsm_pkg for the item type

module tsm_queue import tsm_pkg::*; #(
  parameter int DEPTH = TSM_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  tsm_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output tsm_item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tsm_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  logic             pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue fill count missed a push");

endmodule

[design/tsm_back.sv]
// tsm_back: head store, earliest-head search and result register
// depends on tsm_pkg and tsm_out_if; fed by tsm_queue

module tsm_back import tsm_pkg::*; #(
  parameter int MAX_STREAMS = TSM_MAX_STREAMS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  tsm_cfg_t  cfg,
  input  logic      q_valid,
  output logic      q_ready,
  input  tsm_item_t q_item,
  tsm_out_if.source out_chan
);

  localparam int SIDX_W = $clog2(MAX_STREAMS);
  localparam int CNT_W  = $clog2(MAX_STREAMS + 1);
  localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_EMIT  = 4'b1000
  } tsm_state_t;

  tsm_state_t              state_r;
  tsm_state_t              state_nxt;
  logic [MAX_STREAMS-1:0]  head_valid_r;
  logic [MAX_STREAMS-1:0]  stream_ended_r;
  logic [SEC_W-1:0]        head_sec_r [MAX_STREAMS];
  logic [NS_W-1:0]         head_ns_r  [MAX_STREAMS];
  logic [TAG_W-1:0]        head_tag_r [MAX_STREAMS];
  logic                    done_sent_r;
  logic [SIDX_W-1:0]       scan_idx_r;
  logic                    found_r;
  logic                    emit_done_r;
  logic [SIDX_W-1:0]       best_idx_r;
  logic [SEC_W-1:0]        best_sec_r;
  logic [NS_W-1:0]         best_ns_r;
  logic [TAG_W-1:0]        best_tag_r;
  logic                    out_valid_r;
  logic [ID_W-1:0]         out_stream_r;
  logic [SEC_W-1:0]        out_sec_r;
  logic [NS_W-1:0]         out_ns_r;
  logic [TAG_W-1:0]        out_tag_r;
  logic                    out_done_r;

  logic [CMP_W-1:0]        count_ext;
  logic [CMP_W-1:0]        live_n;
  logic [MAX_STREAMS-1:0]  live;
  logic                    all_ready;
  logic                    any_head;
  logic [CMP_W-1:0]        id_ext;
  logic [SIDX_W-1:0]       id_idx;
  logic                    id_open;
  logic                    pop;
  logic                    write_head;
  logic                    scan_last;
  logic                    better;
  logic [SEC_W-1:0]        cand_sec;
  logic [NS_W-1:0]         cand_ns;
  logic                    out_free;
  logic                    emit_fire;
  logic [CMP_W-1:0]        best_ext;

  // effective stream count, clamped to 1..MAX_STREAMS
  always_comb begin
    count_ext = CMP_W'(cfg.stream_count);
    if (count_ext == '0) begin
      live_n = CMP_W'(1);
    end else if (count_ext > CMP_W'(MAX_STREAMS)) begin
      live_n = CMP_W'(MAX_STREAMS);
    end else begin
      live_n = count_ext;
    end
    for (int i = 0; i < MAX_STREAMS; i++) begin
      live[i] = CMP_W'(i) < live_n;
    end
    all_ready = &(~live | head_valid_r | stream_ended_r);
    any_head  = |(live & head_valid_r);
  end

  // classify the popped item
  assign q_ready    = state_r == ST_IDLE;
  assign pop        = q_valid && q_ready;
  assign id_ext     = CMP_W'(q_item.stream_id);
  assign id_idx     = id_ext[SIDX_W-1:0];
  assign id_open    = (id_ext < live_n) && !stream_ended_r[id_idx];
  assign write_head = pop && id_open && !q_item.eos && !head_valid_r[id_idx];

  // one head compared per cycle, strict compare keeps the lowest index on ties
  always_comb begin
    cand_sec  = head_sec_r[scan_idx_r];
    cand_ns   = head_ns_r[scan_idx_r];
    scan_last = CMP_W'(scan_idx_r) == live_n - 1'b1;
    better    = head_valid_r[scan_idx_r] &&
                (!found_r || (best_sec_r > cand_sec) ||
                 ((best_sec_r == cand_sec) && (best_ns_r > cand_ns)));
  end

  assign out_free  = !out_valid_r || out_chan.ready;
  assign emit_fire = (state_r == ST_EMIT) && out_free;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (pop) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (!all_ready) begin
          state_nxt = ST_IDLE;
        end else if (any_head) begin
          state_nxt = ST_SCAN;
        end else if (!done_sent_r) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (scan_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      head_valid_r   <= '0;
      stream_ended_r <= '0;
      done_sent_r    <= 1'b0;
      scan_idx_r     <= '0;
      found_r        <= 1'b0;
      emit_done_r    <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop && id_open) begin
        if (q_item.eos) begin
          stream_ended_r[id_idx] <= 1'b1;
        end else begin
          head_valid_r[id_idx] <= 1'b1;
        end
      end
      if (state_r == ST_CHECK) begin
        scan_idx_r  <= '0;
        found_r     <= 1'b0;
        emit_done_r <= !any_head;
      end
      if (state_r == ST_SCAN) begin
        scan_idx_r <= scan_idx_r + 1'b1;
        if (better) found_r <= 1'b1;
      end
      if (emit_fire) begin
        if (emit_done_r) begin
          done_sent_r <= 1'b1;
        end else begin
          head_valid_r[best_idx_r] <= 1'b0;
        end
      end
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // head store, running best and result register
  always_ff @(posedge clk) begin
    if (write_head) begin
      head_sec_r[id_idx] <= q_item.sec;
      head_ns_r[id_idx]  <= q_item.ns;
      head_tag_r[id_idx] <= q_item.tag;
    end
    if ((state_r == ST_SCAN) && better) begin
      best_idx_r <= scan_idx_r;
      best_sec_r <= cand_sec;
      best_ns_r  <= cand_ns;
      best_tag_r <= head_tag_r[scan_idx_r];
    end
    if (emit_fire) begin
      out_stream_r <= emit_done_r ? '0 : best_ext[ID_W-1:0];
      out_sec_r    <= emit_done_r ? '0 : best_sec_r;
      out_ns_r     <= emit_done_r ? '0 : best_ns_r;
      out_tag_r    <= emit_done_r ? '0 : best_tag_r;
      out_done_r   <= emit_done_r;
    end
  end

  assign best_ext = CMP_W'(best_idx_r);

  assign out_chan.valid           = out_valid_r;
  assign out_chan.out_stream      = out_stream_r;
  assign out_chan.out_seconds     = out_sec_r;
  assign out_chan.out_nanoseconds = out_ns_r;
  assign out_chan.out_tag         = out_tag_r;
  assign out_chan.all_done        = out_done_r;

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    done_sent_r |=> done_sent_r)
    else $error("done flag dropped without reset");

  a_done_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |->
      (out_sec_r == '0) && (out_ns_r == '0) && (out_tag_r == '0) && (out_stream_r == '0))
    else $error("done result carries nonzero fields");

  a_emit_has_winner: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EMIT) && !emit_done_r) |-> found_r && head_valid_r[best_idx_r])
    else $error("record emitted without a valid winning head");

endmodule

[design/timestamp_stream_merger_top.sv]
// timestamp_stream_merger_top: configuration registers and block wiring
// depends on tsm_pkg, tsm_in_if, tsm_out_if, tsm_front, tsm_queue, tsm_back

// Merges up to MAX_STREAMS timestamped record streams into one stream ordered
// by seconds then nanoseconds, lowest stream index first on ties. Non-L1Accept
// records get the configured signed offset, normalized with nanosecond carry.
// An input transaction is registered in the offset stage, then waits in a
// short queue for the head-store sequencer. The sequencer checks each popped
// transaction; once every live stream holds a head or has ended, it scans the
// heads, comparing one stored head per cycle, and emits the earliest record,
// or emits the final done result once. The result register lets the next
// transaction start while a result waits. Configuration must be written
// through cfg_we/cfg_index/cfg_wdata while idle, not enforced by the block.

module timestamp_stream_merger_top import tsm_pkg::*; #(
  parameter int MAX_STREAMS = TSM_MAX_STREAMS,
  parameter int QUEUE_DEPTH = TSM_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  tsm_in_if.sink                in_chan,
  tsm_out_if.source             out_chan
);

  tsm_cfg_t  cfg_r;
  logic      push_valid;
  logic      push_ready;
  tsm_item_t push_item;
  logic      pop_valid;
  logic      pop_ready;
  tsm_item_t pop_item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stream_count       <= COUNT_W'(1);
      cfg_r.offset_seconds     <= '0;
      cfg_r.offset_nanoseconds <= '0;
    end else if (cfg_we) begin
      case (tsm_cfg_idx_t'(cfg_index))
        CFG_STREAM_COUNT: cfg_r.stream_count       <= cfg_wdata[COUNT_W-1:0];
        CFG_OFFSET_SEC:   cfg_r.offset_seconds     <= cfg_wdata[SEC_W-1:0];
        CFG_OFFSET_NS:    cfg_r.offset_nanoseconds <= cfg_wdata[OFFNS_W-1:0];
        default: ;
      endcase
    end
  end

  tsm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  tsm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  tsm_back #(
    .MAX_STREAMS (MAX_STREAMS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (pop_valid),
    .q_ready  (pop_ready),
    .q_item   (pop_item),
    .out_chan (out_chan)
  );

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking testbench for timestamp_stream_merger_top
// depends on tsm_pkg, tsm_in_if, tsm_out_if and the merger rtl

module tb import tsm_pkg::*; ();

  localparam int     N_STREAMS    = TSM_MAX_STREAMS;
  localparam longint NS_PER_SEC   = 1000000000;
  localparam int     NS_LAST      = 999999999;
  localparam int     NS_FIELD_MAX = 1073741823;
  localparam int     SETTLE_WAIT  = 40;
  localparam int     STALL_LIMIT  = 3000;
  localparam logic signed [OFFNS_W-1:0] OFFNS_MAX = 31'sh3FFF_FFFF;
  localparam logic signed [OFFNS_W-1:0] OFFNS_MIN = 31'sh4000_0000;

  // one input transaction
  typedef struct {
    logic [ID_W-1:0]  stream;
    logic             eos;
    logic [SEC_W-1:0] sec;
    logic [NS_W-1:0]  ns;
    logic             l1;
    logic [TAG_W-1:0] tag;
  } ts_rec_t;

  // one merged result
  typedef struct {
    logic [ID_W-1:0]  stream;
    logic [SEC_W-1:0] sec;
    logic [NS_W-1:0]  ns;
    logic [TAG_W-1:0] tag;
    logic             done;
  } merged_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tsm_in_if  in_chan ();
  tsm_out_if out_chan ();

  timestamp_stream_merger_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  always #5 clk = ~clk;

  // merger state as predicted
  logic [COUNT_W-1:0]        stream_cnt;
  logic [SEC_W-1:0]          shift_sec;
  logic signed [OFFNS_W-1:0] shift_ns;
  logic                      head_ok   [N_STREAMS];
  logic                      ended     [N_STREAMS];
  logic [SEC_W-1:0]          head_sec  [N_STREAMS];
  logic [NS_W-1:0]           head_ns   [N_STREAMS];
  logic [TAG_W-1:0]          head_tag  [N_STREAMS];
  logic                      done_seen;

  merged_t pending_merged [$];

  // stimulus knobs and run counters
  bit               src_gaps;
  bit               sink_gaps;
  int               sink_hold_req;
  logic [SEC_W-1:0] sec_base;
  logic [SEC_W-1:0] tie_sec;
  logic [NS_W-1:0]  tie_ns;
  logic             tie_l1;
  int               errors;
  int               items_sent;
  int               results_seen;
  int               settings_done;

  function automatic int live_streams();
    if (stream_cnt == 0) return 1;
    if (stream_cnt > N_STREAMS) return N_STREAMS;
    return int'(stream_cnt);
  endfunction

  // signed offset with nanosecond carry or borrow into the seconds
  function automatic void shift_time(input logic [SEC_W-1:0] s, input logic [NS_W-1:0] ns,
                                     output logic [SEC_W-1:0] os, output logic [NS_W-1:0] ons);
    longint v;
    longint q;
    longint rem;
    v   = longint'(ns) + longint'(shift_ns) + 3 * NS_PER_SEC;
    q   = v / NS_PER_SEC - 3;
    rem = v % NS_PER_SEC;
    os  = s + shift_sec + q[31:0];
    ons = rem[NS_W-1:0];
  endfunction

  // update the heads with one transaction, pick earliest once all live have one or ended
  function automatic void merge_record(input ts_rec_t r, output bit emit, output merged_t res);
    int  n;
    int  best;
    bit  any_head;
    bit  all_ready;
    n         = live_streams();
    best      = 0;
    any_head  = 0;
    all_ready = 1;
    emit      = 0;
    res       = '{default: '0};
    if (r.stream < n && !ended[r.stream]) begin
      if (r.eos) begin
        ended[r.stream] = 1'b1;
      end else if (!head_ok[r.stream]) begin
        if (r.l1) begin
          head_sec[r.stream] = r.sec;
          head_ns[r.stream]  = r.ns;
        end else begin
          shift_time(r.sec, r.ns, head_sec[r.stream], head_ns[r.stream]);
        end
        head_tag[r.stream] = r.tag;
        head_ok[r.stream]  = 1'b1;
      end
    end
    for (int i = 0; i < n; i++) begin
      if (head_ok[i]) begin
        if (!any_head || head_sec[best] > head_sec[i] ||
            (head_sec[best] == head_sec[i] && head_ns[best] > head_ns[i])) begin
          best = i;
        end
        any_head = 1;
      end else if (!ended[i]) begin
        all_ready = 0;
      end
    end
    if (!all_ready) return;
    if (any_head) begin
      res.stream    = best[ID_W-1:0];
      res.sec       = head_sec[best];
      res.ns        = head_ns[best];
      res.tag       = head_tag[best];
      head_ok[best] = 1'b0;
      emit          = 1;
    end else if (!done_seen) begin
      res.done  = 1'b1;
      done_seen = 1'b1;
      emit      = 1;
    end
  endfunction

  function automatic void clear_model();
    stream_cnt = 1;
    shift_sec  = '0;
    shift_ns   = '0;
    done_seen  = 1'b0;
    for (int i = 0; i < N_STREAMS; i++) begin
      head_ok[i]  = 1'b0;
      ended[i]    = 1'b0;
      head_sec[i] = '0;
      head_ns[i]  = '0;
      head_tag[i] = '0;
    end
  endfunction

  // a live stream with no head, or -1
  function automatic int open_stream();
    int list [$];
    for (int i = 0; i < live_streams(); i++) begin
      if (!ended[i] && !head_ok[i]) list.insert(list.size(), i);
    end
    if (list.size() == 0) return -1;
    return list[$urandom_range(0, list.size() - 1)];
  endfunction

  function automatic bit any_head_left();
    for (int i = 0; i < N_STREAMS; i++) begin
      if (head_ok[i]) return 1;
    end
    return 0;
  endfunction

  function automatic ts_rec_t record_of(input int stream, input logic [SEC_W-1:0] s,
                                        input logic [NS_W-1:0] ns, input logic l1,
                                        input logic [TAG_W-1:0] tag);
    ts_rec_t r;
    r.stream = stream[ID_W-1:0];
    r.eos    = 1'b0;
    r.sec    = s;
    r.ns     = ns;
    r.l1     = l1;
    r.tag    = tag;
    return r;
  endfunction

  // end mark, the other fields random since they are ignored
  function automatic ts_rec_t end_mark(input int stream);
    ts_rec_t r;
    r     = record_of(stream, $urandom, NS_W'($urandom_range(0, NS_FIELD_MAX)),
                      1'($urandom_range(0, 1)), $urandom);
    r.eos = 1'b1;
    return r;
  endfunction

  // random record, mostly close to the phase base so ordering matters
  function automatic ts_rec_t make_rec(input int stream);
    ts_rec_t r;
    r = record_of(stream, '0, '0, 1'($urandom_range(0, 1)), $urandom);
    case ($urandom_range(0, 9))
      0: begin
        r.sec = $urandom;
        r.ns  = NS_W'($urandom_range(0, NS_FIELD_MAX));
      end
      1: begin
        r.sec = tie_sec;
        r.ns  = tie_ns;
        r.l1  = tie_l1;
      end
      2: begin
        r.sec = sec_base + $urandom_range(0, 3);
        r.ns  = NS_W'($urandom_range(NS_LAST + 1, NS_FIELD_MAX));
      end
      default: begin
        r.sec = sec_base + $urandom_range(0, 3);
        r.ns  = NS_W'($urandom_range(0, NS_LAST));
      end
    endcase
    tie_sec = r.sec;
    tie_ns  = r.ns;
    tie_l1  = r.l1;
    return r;
  endfunction

  function automatic logic [SEC_W-1:0] pick_shift_sec();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [OFFNS_W-1:0] pick_shift_ns();
    int v;
    v = int'($urandom_range(0, 2 * NS_LAST)) - NS_LAST;
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 31'sd999999999;
      2:       return -31'sd999999999;
      3:       return OFFNS_MAX;
      4:       return OFFNS_MIN;
      default: return v[OFFNS_W-1:0];
    endcase
  endfunction

  function automatic void flag_mismatch(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    errors++;
  endfunction

  // drive one transaction, predict it once accepted, then maybe idle
  task automatic send_rec(input ts_rec_t r);
    bit      emit;
    merged_t res;
    in_chan.valid            <= 1'b1;
    in_chan.stream_id        <= r.stream;
    in_chan.end_of_stream    <= r.eos;
    in_chan.time_seconds     <= r.sec;
    in_chan.time_nanoseconds <= r.ns;
    in_chan.is_l1accept      <= r.l1;
    in_chan.record_tag       <= r.tag;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    merge_record(r, emit, res);
    if (emit) pending_merged.insert(pending_merged.size(), res);
    items_sent++;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // well-formed record to a stream lacking a head, or noise
  task automatic send_mixed(input int noise_pct);
    int s;
    s = open_stream();
    if (s < 0 || $urandom_range(0, 99) < noise_pct) s = $urandom_range(0, N_STREAMS - 1);
    send_rec(make_rec(s));
  endtask

  // stop sending, wait for every expected result, then let the block go quiet
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (pending_merged.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic configure(input logic [COUNT_W-1:0] count, input logic [SEC_W-1:0] osec,
                           input logic signed [OFFNS_W-1:0] ons);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_STREAM_COUNT;
    cfg_wdata <= CFG_DATA_W'(count);
    @(posedge clk);
    cfg_index <= CFG_OFFSET_SEC;
    cfg_wdata <= osec;
    @(posedge clk);
    cfg_index <= CFG_OFFSET_NS;
    cfg_wdata <= {ons[OFFNS_W-1], ons};
    @(posedge clk);
    cfg_we     <= 1'b0;
    stream_cnt = count;
    shift_sec  = osec;
    shift_ns   = ons;
    settings_done++;
  endtask

  // single stream at reset count: extremes, ignored ids, count of zero
  task automatic test_single_stream();
    send_rec(record_of(0, 32'h0, 30'd0, 1'b1, 32'h0));
    send_rec(record_of(0, 32'hFFFF_FFFF, NS_W'(NS_FIELD_MAX), 1'b0, 32'hFFFF_FFFF));
    send_rec(record_of(0, 32'hFFFF_FFFF, NS_W'(NS_FIELD_MAX), 1'b1, 32'h5A5A_A5A5));
    send_rec(record_of(7, 32'h1234_5678, 30'd77, 1'b0, 32'h0000_0007));
    send_rec(end_mark(5));
    settle();
    configure(4'd0, 32'h0, '0);
    send_rec(record_of(1, 32'h10, 30'd10, 1'b1, 32'h0000_0001));
    send_rec(record_of(0, 32'h10, NS_W'(NS_LAST), 1'b1, 32'hA5A5_5A5A));
  endtask

  // offset extremes with carry and borrow of up to two seconds
  task automatic test_offset_carry();
    settle();
    configure(4'd1, 32'h7FFF_FFFF, OFFNS_MAX);
    send_rec(record_of(0, 32'h1, NS_W'(NS_FIELD_MAX), 1'b0, 32'h1111_1111));
    send_rec(record_of(0, 32'h1, NS_W'(NS_FIELD_MAX), 1'b1, 32'h2222_2222));
    settle();
    configure(4'd1, 32'h8000_0000, OFFNS_MIN);
    send_rec(record_of(0, 32'h0, 30'd0, 1'b0, 32'h3333_3333));
    settle();
    configure(4'd1, 32'hFFFF_FFFF, -31'sd999999999);
    send_rec(record_of(0, 32'h5, 30'd999999998, 1'b0, 32'h4444_4444));
    settle();
    configure(4'd1, 32'h1, 31'sd999999999);
    send_rec(record_of(0, 32'h9, 30'd1, 1'b0, 32'h5555_5555));
  endtask

  // all eight streams, equal times, dropped record, seconds before nanoseconds
  task automatic test_tie_order();
    settle();
    configure(4'd15, 32'h0, '0);
    for (int i = N_STREAMS - 1; i >= 1; i--) begin
      send_rec(record_of(i, 32'd100, 30'd500, i[0], 32'hC000_0000 | i));
    end
    send_rec(record_of(3, 32'd1, 30'd1, 1'b1, 32'hDEAD_0003));
    send_rec(record_of(0, 32'd100, 30'd500, 1'b0, 32'hC000_0000));
    send_rec(record_of(0, 32'd100, 30'd499, 1'b1, 32'hC000_0100));
    send_rec(record_of(0, 32'd100, 30'd501, 1'b1, 32'hC000_0200));
    send_rec(record_of(1, 32'd99, NS_W'(NS_LAST), 1'b1, 32'hC000_0201));
  endtask

  // random phases, each with its own settings, idling and time base
  task automatic test_random_merge();
    int count_plan [13] = '{8, 3, 9, 2, 15, 5, 1, 7, 4, 8, 6, 0, 8};
    foreach (count_plan[c]) begin
      settle();
      configure(COUNT_W'(count_plan[c]), pick_shift_sec(), pick_shift_ns());
      src_gaps  = $urandom_range(0, 2) != 0;
      sink_gaps = $urandom_range(0, 2) != 0;
      sec_base  = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFE : $urandom;
      repeat (40) send_mixed(15);
    end
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    settle();
    configure(4'd8, pick_shift_sec(), pick_shift_ns());
    src_gaps      = 0;
    sink_gaps     = 0;
    sink_hold_req = 150;
    repeat (40) send_mixed(5);
  endtask

  // five streams end in random order, the rest drain, done comes once
  task automatic test_stream_end();
    int order [5] = '{0, 1, 2, 3, 4};
    int j;
    int tmp;
    int guard;
    settle();
    configure(4'd5, pick_shift_sec(), pick_shift_ns());
    src_gaps  = 1;
    sink_gaps = 1;
    for (int i = 4; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    repeat (8) send_mixed(10);
    foreach (order[k]) begin
      send_rec(end_mark(order[k]));
      send_mixed(20);
      if (k == 0) begin
        send_rec(make_rec(order[0]));
        send_rec(end_mark(order[0]));
      end
    end
    guard = 0;
    while (!done_seen && guard < 20) begin
      send_rec(end_mark($urandom_range(0, 4)));
      guard++;
    end
    send_rec(end_mark(0));
    send_rec(make_rec(2));
  endtask

  // raised count revives streams five to seven, no idling from here on
  task automatic test_revive_streams();
    int guard;
    settle();
    configure(4'd8, pick_shift_sec(), pick_shift_ns());
    src_gaps  = 0;
    sink_gaps = 0;
    repeat (30) send_mixed(15);
    for (int i = 5; i < N_STREAMS; i++) send_rec(end_mark(i));
    guard = 0;
    while (any_head_left() && guard < 20) begin
      send_rec(end_mark($urandom_range(5, N_STREAMS - 1)));
      guard++;
    end
  endtask

  // check each result transaction against the oldest prediction
  always @(posedge clk) begin
    merged_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_merged.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, got stream %0d tag %0h done %0b",
                 $time, out_chan.out_stream, out_chan.out_tag, out_chan.all_done);
        errors++;
      end else begin
        want = pending_merged.pop_front();
        results_seen++;
        if (out_chan.out_stream !== want.stream)
          flag_mismatch("out_stream", 32'(want.stream), 32'(out_chan.out_stream));
        if (out_chan.out_seconds !== want.sec)
          flag_mismatch("out_seconds", want.sec, out_chan.out_seconds);
        if (out_chan.out_nanoseconds !== want.ns)
          flag_mismatch("out_nanoseconds", 32'(want.ns), 32'(out_chan.out_nanoseconds));
        if (out_chan.out_tag !== want.tag)
          flag_mismatch("out_tag", want.tag, out_chan.out_tag);
        if (out_chan.all_done !== want.done)
          flag_mismatch("all_done", 32'(want.done), 32'(out_chan.all_done));
      end
    end
  end

  // receiver: random stall bursts and the long hold-off
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_req > 0) begin
        out_chan.ready <= 1'b0;
        repeat (sink_hold_req) @(posedge clk);
        sink_hold_req = 0;
        out_chan.ready <= 1'b1;
      end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 6) - 1) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("timeout: no transaction for %0d cycles at %0t", STALL_LIMIT, $time);
    $display("TB_ERROR");
    $finish;
  end

  // test sequence
  initial begin
    in_chan.valid            <= 1'b0;
    in_chan.stream_id        <= '0;
    in_chan.end_of_stream    <= 1'b0;
    in_chan.time_seconds     <= '0;
    in_chan.time_nanoseconds <= '0;
    in_chan.is_l1accept      <= 1'b0;
    in_chan.record_tag       <= '0;
    cfg_we                   <= 1'b0;
    cfg_index                <= CFG_STREAM_COUNT;
    cfg_wdata                <= '0;
    rst_n                    <= 1'b0;
    src_gaps      = 1;
    sink_gaps     = 1;
    sink_hold_req = 0;
    sec_base      = 32'h0000_1000;
    tie_sec       = '0;
    tie_ns        = '0;
    tie_l1        = 1'b0;
    errors        = 0;
    items_sent    = 0;
    results_seen  = 0;
    settings_done = 0;
    clear_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_single_stream();
    test_offset_carry();
    test_tie_order();
    test_random_merge();
    test_backpressure();
    test_stream_end();
    test_revive_streams();
    settle();

    $display("run covered %0d input transactions, %0d merged results, %0d register settings",
             items_sent, results_seen, settings_done);
    $display("with offset carry and borrow, tie order, back pressure, stream end and done");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
